// ----- sv/tmps_pkg.sv -----
// shared widths and constants for the triangle max path sum block
package tmps_pkg;

  localparam int ROW_COUNT_BITS = 9;
  localparam int ROW_INDEX_BITS = 8;
  localparam int ROW_BEST_BITS  = 24;
  localparam int ROW_STEP_BITS  = 25;

  localparam logic [ROW_COUNT_BITS-1:0] ROW_COUNT_RESET = ROW_COUNT_BITS'(1);

  typedef logic [ROW_COUNT_BITS-1:0] row_count_t;

endpackage

// ----- sv/tmps_cell_if.sv -----
// valid/ready channel carrying one triangle cell per transaction
interface tmps_cell_if #(
  parameter int VALUE_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface

// ----- sv/tmps_row_if.sv -----
// valid/ready channel carrying one row summary per transaction
interface tmps_row_if
  import tmps_pkg::*;
();
  logic                            valid;
  logic                            ready;
  logic [ROW_INDEX_BITS-1:0]       row_index;
  logic signed [ROW_BEST_BITS-1:0] row_best;
  logic signed [ROW_STEP_BITS-1:0] row_step;
  logic                            last_row;

  modport source (output valid, output row_index, output row_best, output row_step,
                  output last_row, input ready);
  modport sink   (input valid, input row_index, input row_best, input row_step,
                  input last_row, output ready);
endinterface

// ----- sv/triangle_max_path_sum_core.sv -----
// triangle max path sum core: row score memory with prefetch and row summary output
//
// Cells of a number triangle arrive on cell_in in row-major order, row r holding
// r+1 cells. Each transaction adds the cell value to the best of up to three
// neighbor scores of the previous row, kept in a single-port-write, one-read
// synchronous score memory indexed by column. When a row's last cell is taken,
// one transaction on row_out gives the row index, the row's best score, the
// change from the previous row's best and a last-row flag; after the last row
// the next cell starts a new triangle. cfg_wr_en/cfg_wr_data set the row count.
// Throughput: one cell per cycle. The memory is read ahead at the
// column after the next cell's, so the next cell's right neighbor is ready when
// it arrives; a same-address write in the cycle of that read is forwarded.
// Latency: a row summary is valid on row_out the cycle after its last cell.
// A stalled row_out holds its summary and blocks only a row-final cell; all
// other cells keep flowing. Reset (rst, synchronous) returns to row 0, column
// 0, row count 1, with no pending summary; the score memory is not cleared.
module triangle_max_path_sum_core
  import tmps_pkg::*;
#(
  parameter int MAX_ROWS   = 256,
  parameter int VALUE_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [ROW_COUNT_BITS-1:0] cfg_wr_data,
  tmps_cell_if.sink                 cell_in,
  tmps_row_if.source                row_out
);

  localparam int RB = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SB = VALUE_BITS + RB;

  typedef logic [RB-1:0]        pos_t;
  typedef logic signed [SB-1:0] score_t;

  // configuration
  row_count_t row_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= ROW_COUNT_RESET;
    end else if (cfg_wr_en) begin
      row_count <= cfg_wr_data;
    end
  end

  // position and window state
  pos_t   row, col;
  pos_t   row_next, col_next;
  score_t win_left, win_mid, row_first, running_best, previous_best;
  score_t mem_q, fwd_data;
  logic   fwd_hit;

  score_t mem [MAX_ROWS];

  logic        accept, row_end, last;
  logic [31:0] limit;
  score_t      right_val, best, score, best_now;
  logic        have, mid_ok, left_ok, right_ok;
  pos_t        rd_addr;
  logic signed [SB:0] step_val;

  assign row_end = (col == row);

  always_comb begin
    limit = 32'(row_count);
    if (limit == 32'd0) begin
      limit = 32'd1;
    end
    if (limit > 32'(MAX_ROWS)) begin
      limit = 32'(MAX_ROWS);
    end
  end

  assign last = (32'(row) + 32'd1) >= limit;

  assign cell_in.ready = !(row_out.valid && !row_out.ready && row_end);
  assign accept        = cell_in.valid && cell_in.ready;

  assign right_val = fwd_hit ? fwd_data : mem_q;
  assign mid_ok    = col < row;
  assign left_ok   = col != '0;
  assign right_ok  = (32'(col) + 32'd1) < 32'(row);

  always_comb begin
    best = '0;
    have = 1'b0;
    if (mid_ok) begin
      best = win_mid;
      have = 1'b1;
    end
    if (left_ok) begin
      if (!have || win_left > best) begin
        best = win_left;
      end
      have = 1'b1;
    end
    if (right_ok) begin
      if (!have || right_val > best) begin
        best = right_val;
      end
      have = 1'b1;
    end
    score = have ? best + SB'(cell_in.cell_value) : SB'(cell_in.cell_value);
    best_now = (col == '0 || score > running_best) ? score : running_best;
    step_val = (row == '0) ? (SB+1)'(best_now)
                           : (SB+1)'(best_now) - (SB+1)'(previous_best);
  end

  always_comb begin
    row_next = row;
    col_next = col;
    if (accept) begin
      if (row_end) begin
        col_next = '0;
        row_next = last ? '0 : RB'(32'(row) + 32'd1);
      end else begin
        col_next = RB'(32'(col) + 32'd1);
      end
    end
    rd_addr = RB'(32'(col_next) + 32'd1);
  end

  // score memory: write the accepted cell, prefetch the next cell's right neighbor
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[col] <= score;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    fwd_data <= score;
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= accept && (rd_addr == col);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row           <= '0;
      col           <= '0;
      win_left      <= '0;
      win_mid       <= '0;
      row_first     <= '0;
      running_best  <= '0;
      previous_best <= '0;
    end else begin
      row <= row_next;
      col <= col_next;
      if (accept) begin
        if (col == '0) begin
          row_first <= score;
        end
        if (row_end) begin
          win_left      <= '0;
          win_mid       <= (col == '0) ? score : row_first;
          previous_best <= last ? '0 : best_now;
          running_best  <= '0;
        end else begin
          win_left     <= win_mid;
          win_mid      <= right_val;
          running_best <= best_now;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      row_out.valid <= 1'b0;
    end else if (accept && row_end) begin
      row_out.valid <= 1'b1;
    end else if (row_out.ready) begin
      row_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && row_end) begin
      row_out.row_index <= ROW_INDEX_BITS'(row);
      row_out.row_best  <= ROW_BEST_BITS'(64'(best_now));
      row_out.row_step  <= ROW_STEP_BITS'(64'(step_val));
      row_out.last_row  <= last;
    end
  end

  // checks
  a_col_in_row: assert property (@(posedge clk) disable iff (rst) col <= row)
    else $error("column beyond row");

  a_row_result: assert property (@(posedge clk) disable iff (rst)
    (accept && row_end) |=> row_out.valid)
    else $error("row summary missing");

  a_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && row_end && last) |=> (row == '0 && col == '0))
    else $error("no restart after last row");

  a_fwd: assert property (@(posedge clk) disable iff (rst)
    fwd_hit |-> $past(accept))
    else $error("forward without write");

endmodule
